// File: rtl/core/wmcp_pkg.sv
// shared types, constants and color ramps of the window max colormap pixel block
package wmcp_pkg;

    localparam int LEVEL_W       = 16;
    localparam int RAMP_ENTRIES  = 14;
    localparam int FRACTION_BITS = 16;
    localparam int CHAN_W        = 8;

    // 80 dB in q8.8 is 5 * 2^12
    localparam int RANGE_Q88   = 20480;
    localparam int RANGE_SHIFT = 12;
    localparam int RANGE_ODD   = 5;

    localparam int CFG_INDEX_W = 2;

    localparam int U_W   = $clog2(RANGE_Q88 + 1);
    localparam int V_W   = $clog2(RANGE_Q88 * (RAMP_ENTRIES - 1) + 1);
    localparam longint unsigned Y_MAX =
        ((64'(RANGE_Q88) * 64'(RAMP_ENTRIES - 1)) << FRACTION_BITS) >> RANGE_SHIFT;
    localparam int Y_W   = $clog2(Y_MAX + 64'd1);
    localparam int P_W   = $clog2((64'(RAMP_ENTRIES - 1) << FRACTION_BITS) + 64'd1);
    localparam int IDX_W = $clog2(RAMP_ENTRIES);

    // reciprocal of the odd factor, exact for every y below 2^Y_W
    localparam int RECIP_SHIFT = Y_W + 2;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(RANGE_ODD - 1)) / 64'(RANGE_ODD);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PEAK_LEVEL     = 2'd0,
        CFG_PALETTE_SELECT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] peak_level;
        logic                      palette_select;
    } cfg_t;

    typedef logic [3*CHAN_W-1:0] rgb_t;

    localparam rgb_t RAMP_DARK [RAMP_ENTRIES] = '{
        24'h1a1a19, 24'h0d366b, 24'h104281, 24'h184f95, 24'h1c5cab,
        24'h256abf, 24'h2a78d6, 24'h3987e5, 24'h5598e7, 24'h6da7ec,
        24'h86b6ef, 24'h9ec5f4, 24'hb7d3f6, 24'hcde2fb
    };

    localparam rgb_t RAMP_LIGHT [RAMP_ENTRIES] = '{
        24'hfcfcfb, 24'hcde2fb, 24'hb7d3f6, 24'h9ec5f4, 24'h86b6ef,
        24'h6da7ec, 24'h5598e7, 24'h3987e5, 24'h2a78d6, 24'h256abf,
        24'h1c5cab, 24'h184f95, 24'h104281, 24'h0d366b
    };

    function automatic rgb_t ramp_color(input logic light, input logic [IDX_W-1:0] idx);
        rgb_t c;
        if (light)
        begin
            c = RAMP_LIGHT[idx];
        end
        else
        begin
            c = RAMP_DARK[idx];
        end
        return c;
    endfunction

endpackage

// File: rtl/core/wmcp_window_max.sv
// running maximum over one window, hands the window maximum to the next stage
module wmcp_window_max (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [wmcp_pkg::LEVEL_W-1:0] level_db,
    input  logic                                window_last,
    output logic                                max_valid,
    input  logic                                max_ready,
    output logic signed [wmcp_pkg::LEVEL_W-1:0] max_level
);

    logic signed [wmcp_pkg::LEVEL_W-1:0] running_max_reg, running_max_next;
    logic                                window_open_reg, window_open_next;
    logic signed [wmcp_pkg::LEVEL_W-1:0] max_level_reg, max_level_next;
    logic                                max_valid_reg, max_valid_next;
    logic                                stage_ready;
    logic                                accept;
    logic signed [wmcp_pkg::LEVEL_W-1:0] new_max;

    assign stage_ready = !max_valid_reg || max_ready;
    assign in_stall    = !stage_ready;
    assign accept      = in_valid && stage_ready;

    // first cell of a window restarts the maximum
    assign new_max = (!window_open_reg || (level_db > running_max_reg)) ?
                     level_db : running_max_reg;

    always_comb
    begin
        running_max_next = running_max_reg;
        window_open_next = window_open_reg;
        max_level_next   = max_level_reg;
        max_valid_next   = max_valid_reg;
        if (stage_ready)
        begin
            max_valid_next = accept && window_last;
        end
        if (accept)
        begin
            running_max_next = new_max;
            window_open_next = !window_last;
            if (window_last)
            begin
                max_level_next = new_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_max_reg <= '0;
            window_open_reg <= 1'b0;
            max_valid_reg   <= 1'b0;
        end
        else
        begin
            running_max_reg <= running_max_next;
            window_open_reg <= window_open_next;
            max_valid_reg   <= max_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_level_reg <= max_level_next;
    end

    assign max_valid = max_valid_reg;
    assign max_level = max_level_reg;

endmodule

// File: rtl/core/wmcp_position.sv
// places the window maximum on the 80 dB scale and scales it onto the ramp
module wmcp_position (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                max_valid,
    output logic                                max_ready,
    input  logic signed [wmcp_pkg::LEVEL_W-1:0] max_level,
    input  logic signed [wmcp_pkg::LEVEL_W-1:0] peak_level,
    output logic                                pos_valid,
    input  logic                                pos_ready,
    output logic        [wmcp_pkg::P_W-1:0]     position
);

    logic signed [wmcp_pkg::LEVEL_W+1:0]            u_raw;
    logic        [wmcp_pkg::U_W-1:0]                u_clamp;
    logic        [wmcp_pkg::V_W-1:0]                v;
    logic        [wmcp_pkg::V_W+wmcp_pkg::FRACTION_BITS-1:0] v_scaled;
    logic        [wmcp_pkg::Y_W-1:0]                y;
    logic        [2*wmcp_pkg::Y_W-1:0]              prod;
    logic        [wmcp_pkg::P_W-1:0]                position_reg, position_next;
    logic                                           pos_valid_reg, pos_valid_next;
    logic                                           stage_ready;

    assign stage_ready = !pos_valid_reg || pos_ready;
    assign max_ready   = stage_ready;

    always_comb
    begin
        u_raw = (wmcp_pkg::LEVEL_W+2)'(max_level) - (wmcp_pkg::LEVEL_W+2)'(peak_level)
              + (wmcp_pkg::LEVEL_W+2)'(wmcp_pkg::RANGE_Q88);
        if (u_raw < 0)
        begin
            u_clamp = '0;
        end
        else if (u_raw > (wmcp_pkg::LEVEL_W+2)'(wmcp_pkg::RANGE_Q88))
        begin
            u_clamp = wmcp_pkg::U_W'(wmcp_pkg::RANGE_Q88);
        end
        else
        begin
            u_clamp = wmcp_pkg::U_W'(u_raw);
        end
        v        = wmcp_pkg::V_W'(u_clamp) * wmcp_pkg::V_W'(wmcp_pkg::RAMP_ENTRIES - 1);
        // divide by the power of two part of the range first, then by the odd part
        v_scaled = {v, {wmcp_pkg::FRACTION_BITS{1'b0}}};
        y        = wmcp_pkg::Y_W'(v_scaled >> wmcp_pkg::RANGE_SHIFT);
        prod     = (2*wmcp_pkg::Y_W)'(y) * (2*wmcp_pkg::Y_W)'(wmcp_pkg::RECIP);
        position_next  = position_reg;
        pos_valid_next = pos_valid_reg;
        if (stage_ready)
        begin
            pos_valid_next = max_valid;
            if (max_valid)
            begin
                position_next = wmcp_pkg::P_W'(prod >> wmcp_pkg::RECIP_SHIFT);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= 1'b0;
        end
        else
        begin
            pos_valid_reg <= pos_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg <= position_next;
    end

    assign pos_valid = pos_valid_reg;
    assign position  = position_reg;

endmodule

// File: rtl/core/wmcp_blend.sv
// ramp segment lookup and per channel linear interpolation into the output register
module wmcp_blend (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pos_valid,
    output logic                            pos_ready,
    input  logic [wmcp_pkg::P_W-1:0]        position,
    input  logic                            palette_select,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wmcp_pkg::CHAN_W-1:0]     red,
    output logic [wmcp_pkg::CHAN_W-1:0]     green,
    output logic [wmcp_pkg::CHAN_W-1:0]     blue
);

    localparam int F     = wmcp_pkg::FRACTION_BITS;
    localparam int NUM_W = F + 10;
    localparam int CW    = wmcp_pkg::CHAN_W;

    function automatic logic [CW-1:0] blend_channel(
        input logic [CW-1:0] a,
        input logic [CW-1:0] b,
        input logic [F:0]    f
    );
        logic signed [CW:0]      diff;
        logic signed [NUM_W-1:0] num;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        // a*2^F + (b-a)*f + half, never negative
        num  = (NUM_W'($signed({1'b0, a})) <<< F)
             + NUM_W'(diff) * NUM_W'($signed({1'b0, f}))
             + (NUM_W'(1) <<< (F - 1));
        return num[F+CW-1:F];
    endfunction

    logic [wmcp_pkg::P_W-F-1:0]   seg_raw;
    logic [wmcp_pkg::IDX_W-1:0]   seg;
    logic [F:0]                   frac;
    wmcp_pkg::rgb_t               color_a;
    wmcp_pkg::rgb_t               color_b;
    wmcp_pkg::rgb_t               rgb_reg, rgb_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         stage_ready;

    assign stage_ready = !out_valid_reg || !out_stall;
    assign pos_ready   = stage_ready;

    always_comb
    begin
        seg_raw = position[wmcp_pkg::P_W-1:F];
        if (seg_raw > (wmcp_pkg::P_W-F)'(wmcp_pkg::RAMP_ENTRIES - 2))
        begin
            seg = wmcp_pkg::IDX_W'(wmcp_pkg::RAMP_ENTRIES - 2);
        end
        else
        begin
            seg = wmcp_pkg::IDX_W'(seg_raw);
        end
        frac    = (F+1)'(position - (wmcp_pkg::P_W'(seg) << F));
        color_a = wmcp_pkg::ramp_color(palette_select, seg);
        color_b = wmcp_pkg::ramp_color(palette_select, seg + wmcp_pkg::IDX_W'(1));
        rgb_next       = rgb_reg;
        out_valid_next = out_valid_reg;
        if (stage_ready)
        begin
            out_valid_next = pos_valid;
            if (pos_valid)
            begin
                rgb_next = {blend_channel(color_a[3*CW-1:2*CW], color_b[3*CW-1:2*CW], frac),
                            blend_channel(color_a[2*CW-1:CW], color_b[2*CW-1:CW], frac),
                            blend_channel(color_a[CW-1:0], color_b[CW-1:0], frac)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign out_valid = out_valid_reg;
    assign red       = rgb_reg[3*CW-1:2*CW];
    assign green     = rgb_reg[2*CW-1:CW];
    assign blue      = rgb_reg[CW-1:0];

endmodule

// File: rtl/core/window_max_colormap_pixel.sv
// top level of the window max colormap pixel block
//
// input channel: level_db (signed q8.8) and window_last, moved by in_valid and
// in_stall; a transaction happens on a rising edge with in_valid high and
// in_stall low. the cells of one window come in a row, the last one marked.
// output channel: one red/green/blue pixel per window on out_valid, held until
// a transaction with out_stall low.
// config channel: cfg_index/cfg_data on cfg_valid, always ready; index 0 is
// peak_level, index 1 palette_select, other indexes are dropped. write only
// while no pixel is in flight.
// throughput: one cell per cycle, sustained while in_stall is low, with no bubbles between windows.
// the marked cell's transaction reaches out_valid through the window register,
// which takes the maximum at that edge, then the position register
// (reciprocal multiply) and the output register (interpolation multiply).
// a stalled receiver fills the three stage registers, after which in_stall
// rises; nothing is dropped.
// reset clears the running maximum, the open window flag, all stage valid
// flags and both config registers.
module window_max_colormap_pixel (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [wmcp_pkg::LEVEL_W-1:0]     level_db,
    input  logic                                    window_last,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic        [wmcp_pkg::CHAN_W-1:0]      red,
    output logic        [wmcp_pkg::CHAN_W-1:0]      green,
    output logic        [wmcp_pkg::CHAN_W-1:0]      blue,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [wmcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [wmcp_pkg::LEVEL_W-1:0]     cfg_data
);

    wmcp_pkg::cfg_t                      cfg_reg, cfg_next;
    logic                                max_valid;
    logic                                max_ready;
    logic signed [wmcp_pkg::LEVEL_W-1:0] max_level;
    logic                                pos_valid;
    logic                                pos_ready;
    logic        [wmcp_pkg::P_W-1:0]     position;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (wmcp_pkg::cfg_index_t'(cfg_index))
                wmcp_pkg::CFG_PEAK_LEVEL:     cfg_next.peak_level     = $signed(cfg_data);
                wmcp_pkg::CFG_PALETTE_SELECT: cfg_next.palette_select = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wmcp_window_max u_window_max (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level_db    (level_db),
        .window_last (window_last),
        .max_valid   (max_valid),
        .max_ready   (max_ready),
        .max_level   (max_level)
    );

    wmcp_position u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_valid  (max_valid),
        .max_ready  (max_ready),
        .max_level  (max_level),
        .peak_level (cfg_reg.peak_level),
        .pos_valid  (pos_valid),
        .pos_ready  (pos_ready),
        .position   (position)
    );

    wmcp_blend u_blend (
        .clk            (clk),
        .rst_n          (rst_n),
        .pos_valid      (pos_valid),
        .pos_ready      (pos_ready),
        .position       (position),
        .palette_select (cfg_reg.palette_select),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

endmodule

// File: tb/wmcp_colormap_checker.sv
`timescale 1ns / 100ps
// checker for the window max colormap pixel block: tracks window maxima, predicts pixels, compares
module wmcp_colormap_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [wmcp_pkg::LEVEL_W-1:0]     level_db,
    input  logic                                    window_last,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic        [wmcp_pkg::CHAN_W-1:0]      red,
    input  logic        [wmcp_pkg::CHAN_W-1:0]      green,
    input  logic        [wmcp_pkg::CHAN_W-1:0]      blue,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic        [wmcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic        [wmcp_pkg::LEVEL_W-1:0]     cfg_data,
    output int                                      mismatches,
    output int                                      pixels_pending
);

    localparam int DB80_Q88 = 20480;
    localparam int SEGMENTS = 13;
    localparam int FRAC_W   = 16;

    localparam logic [23:0] DARK_RAMP [14] = '{
        24'h1a1a19, 24'h0d366b, 24'h104281, 24'h184f95, 24'h1c5cab,
        24'h256abf, 24'h2a78d6, 24'h3987e5, 24'h5598e7, 24'h6da7ec,
        24'h86b6ef, 24'h9ec5f4, 24'hb7d3f6, 24'hcde2fb
    };

    localparam logic [23:0] LIGHT_RAMP [14] = '{
        24'hfcfcfb, 24'hcde2fb, 24'hb7d3f6, 24'h9ec5f4, 24'h86b6ef,
        24'h6da7ec, 24'h5598e7, 24'h3987e5, 24'h2a78d6, 24'h256abf,
        24'h1c5cab, 24'h184f95, 24'h104281, 24'h0d366b
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    pixel_t             pixels_due [$];
    pixel_t             seen;
    pixel_t             due;
    logic signed [15:0] window_top;
    logic               window_open;
    logic signed [15:0] peak_cfg;
    logic               light_cfg;
    int                 errs = 0;

    function automatic pixel_t colormap_pixel(input logic signed [15:0] top_level,
                                              input logic signed [15:0] peak,
                                              input logic light);
        int              span;
        int              c;
        longint unsigned position;
        longint unsigned segment;
        longint unsigned frac;
        logic [23:0]     lo_rgb;
        logic [23:0]     hi_rgb;
        longint          lo_c;
        longint          hi_c;
        longint          acc;
        logic [7:0]      chan [3];
        pixel_t          pix;
        span = int'(top_level) - int'(peak) + DB80_Q88;
        if (span < 0)
        begin
            span = 0;
        end
        else if (span > DB80_Q88)
        begin
            span = DB80_Q88;
        end
        position = ((64'(span) * 64'(SEGMENTS)) << FRAC_W) / 64'(DB80_Q88);
        segment = position >> FRAC_W;
        // full scale lands on the last segment with a fraction of one
        if (segment > SEGMENTS - 1)
        begin
            segment = SEGMENTS - 1;
        end
        frac = position - (segment << FRAC_W);
        lo_rgb = light ? LIGHT_RAMP[segment] : DARK_RAMP[segment];
        hi_rgb = light ? LIGHT_RAMP[segment + 1] : DARK_RAMP[segment + 1];
        for (c = 0; c < 3; c++)
        begin
            lo_c = longint'(lo_rgb[8*(2-c) +: 8]);
            hi_c = longint'(hi_rgb[8*(2-c) +: 8]);
            acc = (lo_c << FRAC_W) + (hi_c - lo_c) * longint'(frac) + (64'sd1 << (FRAC_W - 1));
            if (acc < 0)
            begin
                acc = 0;
            end
            chan[c] = 8'(acc >> FRAC_W);
        end
        pix.red = chan[0];
        pix.green = chan[1];
        pix.blue = chan[2];
        return pix;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_top = '0;
            window_open = 1'b0;
            peak_cfg = '0;
            light_cfg = 1'b0;
            pixels_due.delete();
            pixels_pending <= 0;
            mismatches <= errs;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.red = red;
                seen.green = green;
                seen.blue = blue;
                if (pixels_due.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                    begin
                        $display("%0t: unexpected pixel r=%02h g=%02h b=%02h",
                                 $realtime, red, green, blue);
                    end
                end
                else
                begin
                    due = pixels_due.pop_front();
                    if (due.red !== seen.red || due.green !== seen.green
                        || due.blue !== seen.blue)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display({"%0t: pixel mismatch, expected r=%02h g=%02h b=%02h,",
                                      " got r=%02h g=%02h b=%02h"},
                                     $realtime, due.red, due.green, due.blue,
                                     seen.red, seen.green, seen.blue);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                // the first cell of a window replaces whatever the max held
                if (!window_open || level_db > window_top)
                begin
                    window_top = level_db;
                end
                window_open = 1'b1;
                if (window_last)
                begin
                    pixels_due.push_back(colormap_pixel(window_top, peak_cfg, light_cfg));
                    window_open = 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wmcp_pkg::CFG_PEAK_LEVEL:     peak_cfg = cfg_data;
                    wmcp_pkg::CFG_PALETTE_SELECT: light_cfg = cfg_data[0];
                    default:                      ;
                endcase
            end
            pixels_pending <= pixels_due.size();
            mismatches <= errs;
        end
    end

endmodule

// File: tb/tb_window_max_colormap_pixel.sv
`timescale 1ns / 100ps
// testbench top for the window max colormap pixel block: stimulus, stalls and verdict
module tb_window_max_colormap_pixel;

    localparam logic [wmcp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [wmcp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int DB80_Q88    = 20480;
    localparam int PHASE_CELLS = 325;
    localparam int CYCLE_LIMIT = 400000;

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    in_valid = 1'b0;
    logic                                    in_stall;
    logic signed [wmcp_pkg::LEVEL_W-1:0]     level_db = '0;
    logic                                    window_last = 1'b0;
    logic                                    out_valid;
    logic                                    out_stall = 1'b0;
    logic        [wmcp_pkg::CHAN_W-1:0]      red;
    logic        [wmcp_pkg::CHAN_W-1:0]      green;
    logic        [wmcp_pkg::CHAN_W-1:0]      blue;
    logic                                    cfg_valid = 1'b0;
    logic                                    cfg_ready;
    logic        [wmcp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic        [wmcp_pkg::LEVEL_W-1:0]     cfg_data = '0;

    int mismatches;
    int pixels_pending;
    int cycles = 0;
    int burst_left = 0;
    int cells_sent = 0;
    int current_peak = 0;
    int stall_mode = 0;
    int stall_left = 0;

    window_max_colormap_pixel u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level_db    (level_db),
        .window_last (window_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    wmcp_colormap_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .level_db       (level_db),
        .window_last    (window_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stalls: none, light, heavy or a fixed 3-of-8 pattern, re-chosen now and then
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 8) < 3);
        endcase
    end

    task automatic push_cell(input logic signed [wmcp_pkg::LEVEL_W-1:0] level,
                             input logic mark_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        level_db <= level;
        window_last <= mark_last;
        do @(posedge clk); while (in_stall);
        cells_sent++;
    endtask

    // hold the sender until every pixel in flight is out
    task automatic drain_pixels();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wmcp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wmcp_pkg::LEVEL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic new_setting(input int peak, input logic [wmcp_pkg::LEVEL_W-1:0] palette_word,
                               input logic [wmcp_pkg::CFG_INDEX_W-1:0] spare_idx,
                               input logic [wmcp_pkg::LEVEL_W-1:0] spare_word);
        drain_pixels();
        write_reg(wmcp_pkg::CFG_PEAK_LEVEL, 16'(peak));
        write_reg(spare_idx, spare_word);
        write_reg(wmcp_pkg::CFG_PALETTE_SELECT, palette_word);
        cfg_valid <= 1'b0;
        @(posedge clk);
        current_peak = peak;
    endtask

    function automatic logic signed [wmcp_pkg::LEVEL_W-1:0] pick_level(input int peak);
        int          v;
        logic [15:0] raw;
        raw = 16'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: v = int'($signed(raw));
            4:          v = -32768;
            5:          v = 32767;
            6:          v = peak;
            7:          v = peak - DB80_Q88 + int'($urandom_range(0, 2)) - 1;
            default:    v = peak + int'($urandom_range(0, 25600)) - 23040;
        endcase
        if (v < -32768)
        begin
            v = -32768;
        end
        else if (v > 32767)
        begin
            v = 32767;
        end
        return 16'(v);
    endfunction

    task automatic run_window();
        int len;
        int k;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (k = 0; k < len; k++)
        begin
            push_cell(pick_level(current_peak), k == len - 1);
        end
    endtask

    task automatic run_phase(input int n);
        int   start;
        logic paused;
        start = cells_sent;
        paused = 1'b0;
        while (cells_sent - start < n)
        begin
            run_window();
            // pause with a window left open, then let it continue
            if (!paused && cells_sent - start >= n / 2)
            begin
                push_cell(pick_level(current_peak), 1'b0);
                drain_pixels();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: peak 0 dB, dark ramp
        push_cell(16'sh0000, 1'b1);
        push_cell(16'sh7fff, 1'b1);
        push_cell(16'sh8000, 1'b1);
        push_cell(-16'sd20480, 1'b1);
        push_cell(-16'sd20479, 1'b1);
        push_cell(-16'sd10240, 1'b1);
        push_cell(-16'sd100, 1'b0);
        push_cell(16'sd500, 1'b0);
        push_cell(16'sh8000, 1'b0);
        push_cell(16'sd200, 1'b1);
        // new window starts below the old maximum
        push_cell(-16'sd30000, 1'b0);
        push_cell(-16'sd25000, 1'b1);
        push_cell(16'sh8000, 1'b0);
        push_cell(16'sh8000, 1'b1);

        new_setting(-32768, 16'h0001, CFG_SPARE_A, 16'h7fff);
        push_cell(16'sh7fff, 1'b1);
        push_cell(16'sh8000, 1'b1);
        push_cell(-16'sd12288, 1'b1);

        new_setting(32767, 16'h0000, CFG_SPARE_B, 16'hffff);
        push_cell(16'sh7fff, 1'b1);
        push_cell(16'sh8000, 1'b1);
        push_cell(16'sd12287, 1'b1);

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       new_setting(-5120, 16'h0001, CFG_SPARE_A, 16'($urandom));
                1:       new_setting(32767, 16'h0000, CFG_SPARE_B, 16'($urandom));
                2:       new_setting(-32768, 16'hfffe, CFG_SPARE_A, 16'($urandom));
                4:       new_setting(0, 16'h8001, CFG_SPARE_B, 16'($urandom));
                default: new_setting(int'($signed(16'($urandom))), 16'($urandom),
                                     CFG_SPARE_A, 16'($urandom));
            endcase
            run_phase(PHASE_CELLS);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wmcp_pkg.sv
rtl/core/wmcp_window_max.sv
rtl/core/wmcp_position.sv
rtl/core/wmcp_blend.sv
rtl/core/window_max_colormap_pixel.sv
tb/wmcp_colormap_checker.sv
tb/tb_window_max_colormap_pixel.sv
